// ===== rtl/fbcs_pkg.sv =====
// Shared types and constants of the fault beep code sequencer.
package fbcs_pkg;

	localparam int unsigned LEN_W   = 16;
	localparam int unsigned DIGIT_W = 8;
	localparam int unsigned APP_W   = 8;
	localparam int unsigned SYS_W   = 16;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned NPHASE  = 8;
	localparam int unsigned IDX_W   = 3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LONG_BEEP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SHORT_BEEP = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIGIT_GAP  = 3'd2;
	localparam logic [IDX_W-1:0] REG_GROUP_GAP  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CYCLE_GAP  = 3'd4;

	// register reset values
	localparam logic [LEN_W-1:0] RST_LONG_BEEP  = 16'd400;
	localparam logic [LEN_W-1:0] RST_SHORT_BEEP = 16'd100;
	localparam logic [LEN_W-1:0] RST_DIGIT_GAP  = 16'd500;
	localparam logic [LEN_W-1:0] RST_GROUP_GAP  = 16'd1500;
	localparam logic [LEN_W-1:0] RST_CYCLE_GAP  = 16'd4000;

	// item kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// first phase, and gap phases with their own length; other gaps use the digit gap
	localparam logic [PHASE_W-1:0] PH_FIRST    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_GROUP_GAP = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CYCLE_GAP = 3'd7;

	// digit counts: app tens, app ones, sys tens, sys ones
	typedef logic [3:0][DIGIT_W-1:0] digits_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [DIGIT_W-1:0] beeps;
		logic               half_on;
		logic [LEN_W-1:0]   time_left;
	} seg_t;

endpackage

// ===== rtl/fbcs_digit_split.sv =====
// Splits the two report codes into tens and ones, truncating toward zero.
module fbcs_digit_split (
	input  logic [fbcs_pkg::APP_W-1:0] app_code,
	input  logic [fbcs_pkg::SYS_W-1:0] sys_code,
	output fbcs_pkg::digits_t          digits
);
	import fbcs_pkg::*;

	logic [18:0] app_prod;
	logic [4:0]  app_tens;
	logic [7:0]  app_ones;
	logic        sys_neg;
	logic [15:0] sys_mag;
	logic [31:0] sys_prod;
	logic [12:0] sys_tens;
	logic [15:0] sys_ones;

	// x*205>>11 is x/10 for x below 1029; x*52429>>19 for x below 43690
	always_comb begin
		app_prod = 19'(app_code) * 19'd205;
		app_tens = app_prod[15:11];
		app_ones = app_code - 8'({app_tens, 3'b000} + {2'b00, app_tens, 1'b0});

		sys_neg  = sys_code[SYS_W-1];
		sys_mag  = sys_neg ? (16'd0 - sys_code) : sys_code;
		sys_prod = 32'(sys_mag) * 32'd52429;
		sys_tens = sys_prod[31:19];
		sys_ones = sys_mag - 16'({sys_tens, 3'b000} + {2'b00, sys_tens, 1'b0});

		digits[0] = DIGIT_W'(app_tens);
		digits[1] = app_ones;
		digits[2] = sys_neg ? (8'd0 - sys_tens[7:0]) : sys_tens[7:0];
		digits[3] = sys_neg ? (8'd0 - sys_ones[7:0]) : sys_ones[7:0];
	end

endmodule

// ===== rtl/fault_beep_code_sequencer.sv =====
// Top level of the fault beep code sequencer: buzzer pattern from two error codes.
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tuser: op; tdata: app_code, sys_code
//  m_*      out  tvalid/tready      tdata: buzzer, reporting
//  cfg_*    in   cfg_we (no wait)   cfg_index, cfg_data (16-bit lengths)
//
// One item per cycle sustained while the result is not stalled; every item gives
// one result, through the input register, then the sequencing step into the
// result register. Reset (arst_n low, asynchronous) stops the pattern and
// restores the default lengths. A stalled result holds the result register and,
// behind it, the input register; s_tready drops only when both are full.
module fault_beep_code_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [7:0] app_code, [23:8] sys_code
	input  logic        s_tuser,    // op: 0 tick, 1 start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [0] buzzer, [1] reporting, [7:2] zero
	input  logic        cfg_we,
	input  logic [fbcs_pkg::IDX_W-1:0] cfg_index,
	input  logic [fbcs_pkg::LEN_W-1:0] cfg_data
);
	import fbcs_pkg::*;

	// configuration
	logic [LEN_W-1:0] long_q, short_q, dgap_q, ggap_q, cgap_q;

	// input register
	logic                 in_valid_s1;
	logic                 op_s1;
	logic [APP_W-1:0]     app_s1;
	logic [SYS_W-1:0]     sys_s1;

	// pattern state
	logic                 running_q;
	seg_t                 seg_q;
	digits_t              digits_q;

	// result register
	logic                 out_valid_q;
	logic                 buzzer_q;
	logic                 reporting_q;

	logic                 advance;
	digits_t              digits_new;
	logic                 start_ok;
	seg_t                 fresh [NPHASE];
	logic [NPHASE-1:0]    live;
	logic                 cur_empty;
	logic                 found;
	logic [PHASE_W-1:0]   sel;
	logic [PHASE_W-1:0]   cand;
	seg_t                 work;
	seg_t                 seg_nxt;
	logic                 level;
	logic [LEN_W-1:0]     tl_dec;
	logic [LEN_W-1:0]     work_len;

	fbcs_digit_split u_split (
		.app_code (app_s1),
		.sys_code (sys_s1),
		.digits   (digits_new)
	);

	assign advance  = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, reporting_q, buzzer_q};

	assign start_ok = (op_s1 == OP_START) && !running_q &&
		((app_s1 != '0) || (sys_s1 != '0));

	// what each phase looks like right after it is loaded, and whether it lasts
	always_comb begin
		for (int p = 0; p < NPHASE; p++) begin
			fresh[p].phase = PHASE_W'(p);
			if (p[0] == 1'b0) begin
				fresh[p].beeps     = digits_q[p >> 1];
				fresh[p].half_on   = 1'b1;
				fresh[p].time_left = p[1] ? short_q : long_q;
				live[p] = (fresh[p].beeps != '0) && (fresh[p].time_left != '0);
			end else begin
				fresh[p].beeps     = '0;
				fresh[p].half_on   = 1'b0;
				if (PHASE_W'(p) == PH_GROUP_GAP)
					fresh[p].time_left = ggap_q;
				else if (PHASE_W'(p) == PH_CYCLE_GAP)
					fresh[p].time_left = cgap_q;
				else
					fresh[p].time_left = dgap_q;
				live[p] = (fresh[p].time_left != '0);
			end
		end
	end

	// an exhausted segment passes to the next phase that has any length; the
	// full turn around comes back to the current phase itself
	always_comb begin
		cur_empty = (seg_q.time_left == '0) ||
			(!seg_q.phase[0] && (seg_q.beeps == '0));
		found = 1'b0;
		sel   = seg_q.phase + 3'd1;
		for (int k = 1; k <= NPHASE; k++) begin
			cand = seg_q.phase + PHASE_W'(k);
			if (!found && live[cand]) begin
				found = 1'b1;
				sel   = cand;
			end
		end
	end

	// one tick on the chosen segment, or the first phase loaded on an accepted start
	always_comb begin
		work     = cur_empty ? fresh[sel] : seg_q;
		work_len = work.phase[1] ? short_q : long_q;
		tl_dec   = work.time_left - 16'd1;
		seg_nxt  = seg_q;
		level    = 1'b0;
		if (op_s1 == OP_START) begin
			if (start_ok) begin
				seg_nxt.phase     = PH_FIRST;
				seg_nxt.beeps     = digits_new[0];
				seg_nxt.half_on   = 1'b1;
				seg_nxt.time_left = long_q;
			end
		end else if (running_q) begin
			if (cur_empty && !found) begin
				// nothing in the pattern has any length: stay silent
				seg_nxt = fresh[sel];
			end else begin
				level   = !work.phase[0] && work.half_on;
				seg_nxt = work;
				seg_nxt.time_left = tl_dec;
				if ((tl_dec == '0) && !work.phase[0]) begin
					// end of a beep half: on half gives way to off, off ends the beep
					if (work.half_on) begin
						seg_nxt.half_on = 1'b0;
					end else begin
						seg_nxt.beeps   = work.beeps - 8'd1;
						seg_nxt.half_on = 1'b1;
					end
					seg_nxt.time_left = work_len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q  <= RST_LONG_BEEP;
			short_q <= RST_SHORT_BEEP;
			dgap_q  <= RST_DIGIT_GAP;
			ggap_q  <= RST_GROUP_GAP;
			cgap_q  <= RST_CYCLE_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_BEEP:  long_q  <= cfg_data;
				REG_SHORT_BEEP: short_q <= cfg_data;
				REG_DIGIT_GAP:  dgap_q  <= cfg_data;
				REG_GROUP_GAP:  ggap_q  <= cfg_data;
				REG_CYCLE_GAP:  cgap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1  <= s_tuser;
			app_s1 <= s_tdata[7:0];
			sys_s1 <= s_tdata[23:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			seg_q     <= '0;
			digits_q  <= '0;
		end else if (advance) begin
			seg_q <= seg_nxt;
			if (start_ok) begin
				running_q <= 1'b1;
				digits_q  <= digits_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buzzer_q    <= level;
			reporting_q <= running_q || start_ok;
		end
	end

endmodule
